/* sv/bti_pkg.sv */
// ----------------------------------------------------------------------------
// bti_pkg: shared types and constants for the bilinear table interpolator
// Holds the item structs, operation codes and controller states.
// ----------------------------------------------------------------------------
package bti_pkg;

  localparam int CoordW = 32;
  localparam int ValueW = 48;

  typedef enum logic [1:0] {
    OP_LOAD_X = 2'd0,
    OP_LOAD_Y = 2'd1,
    OP_LOAD_V = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  localparam logic [0:0] CFG_X_COUNT = 1'b0;
  localparam logic [0:0] CFG_Y_COUNT = 1'b1;

  typedef struct packed {
    logic [1:0]         operation;
    logic [5:0]         row_index;
    logic [6:0]         col_index;
    logic signed [31:0] grid_value;
    logic signed [47:0] entry_value;
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] interp_value;
    logic               out_of_range;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_XPROBE,   // read x[1], x[n-2], x[0], x[n-1]
    ST_XWAIT,
    ST_XSCAN,
    ST_XSCAN_W,
    ST_YPROBE,
    ST_YWAIT,
    ST_YSCAN,
    ST_YSCAN_W,
    ST_CELL,
    ST_FETCH,
    ST_FETCH_W,
    ST_MUL,
    ST_DIV,
    ST_DIV_W,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic       probe;     // issue grid probe read
    logic       probe_y;   // 1: y grid
    logic [1:0] probe_sel; // which probe point
    logic       scan;      // read grid at scan index
    logic       scan_step; // advance scan index
    logic       scan_init;
    logic       cell_latch; // latch cell ends
    logic       fetch;     // read table entry
    logic [1:0] fetch_sel;
    logic       mul_go;
    logic [1:0] lerp_sel;  // 0 gb, 1 ga, 2 x
    logic       div_go;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic range_ok;
    logic scan_stop;
    logic dy_zero;
    logic dx_zero;
    logic div_done;
  } sts_t;

endpackage

/* sv/bti_divider.sv */
// ----------------------------------------------------------------------------
// bti_divider: restoring divider, one quotient bit per cycle
// Rounds half away from zero and saturates to 48-bit signed.
// ----------------------------------------------------------------------------
module bti_divider (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic signed [96:0] num,
  input  logic signed [32:0] den,
  output logic               done,
  output logic signed [47:0] quo
);
  import bti_pkg::*;

  logic [96:0] n;
  logic [32:0] d;
  logic [33:0] rem;
  logic [96:0] q;
  logic [6:0]  cnt;
  logic        neg;
  logic        busy;
  logic [33:0] rem_sh;
  logic [97:0] qr;
  logic [47:0] lim;

  assign rem_sh = {rem[32:0], n[96]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= 7'd97;
        neg  <= num[96] ^ den[32];
        n    <= num[96] ? 97'(-num) : 97'(num);
        d    <= den[32] ? 33'(-den) : 33'(den);
        rem  <= '0;
        q    <= '0;
      end else if (busy) begin
        n <= {n[95:0], 1'b0};
        if (rem_sh >= {1'b0, d}) begin
          rem <= rem_sh - {1'b0, d};
          q   <= {q[95:0], 1'b1};
        end else begin
          rem <= rem_sh;
          q   <= {q[95:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // round: rem >= d - rem  <=>  2*rem >= d
  always_comb begin
    qr  = {1'b0, q} + (({rem, 1'b0} >= {2'b0, d}) ? 98'd1 : 98'd0);
    lim = neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    if (qr > {50'b0, lim}) quo = neg ? $signed(lim) : $signed(lim);
    else quo = neg ? $signed(48'(-qr[47:0])) : $signed(qr[47:0]);
  end
endmodule

/* sv/bti_datapath.sv */
// ----------------------------------------------------------------------------
// bti_datapath: grid and table memories, cell search registers, arithmetic
// Runs the reads, compares, multiplies and division the controller orders.
// ----------------------------------------------------------------------------
module bti_datapath #(
  parameter int MAX_X_POINTS = 64,
  parameter int MAX_Y_POINTS = 128
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load_en,
  input  bti_pkg::in_item_t      item,
  input  logic [6:0]             x_count,
  input  logic [7:0]             y_count,
  input  bti_pkg::cmd_t          cmd,
  output bti_pkg::sts_t          sts,
  output bti_pkg::out_item_t     result
);
  import bti_pkg::*;

  localparam int XA = $clog2(MAX_X_POINTS);
  localparam int YA = $clog2(MAX_Y_POINTS);
  localparam int CA = (XA > YA) ? XA : YA;

  logic signed [31:0] xmem [MAX_X_POINTS];
  logic signed [31:0] ymem [MAX_Y_POINTS];
  logic signed [47:0] vmem [1 << (XA + YA)];

  in_item_t q;
  logic [XA-1:0] nx1;
  logic [YA-1:0] ny1;
  logic signed [31:0] rd;      // registered grid read
  logic signed [47:0] vrd;     // registered table read
  logic [CA-1:0] raddr, iidx, start, endi;
  logic asc, cur_y;
  logic signed [31:0] g1, gn2, gs, ge;
  logic [XA-1:0] ih, il;
  logic [YA-1:0] jh, jl;
  logic [XA-1:0] ce_x;
  logic [YA-1:0] ce_y;
  logic signed [31:0] xh, xl, yh, yl;
  logic signed [47:0] fa0, fb0, fa1, fb1, ga, gb;
  logic signed [96:0] prod_a, prod_b;
  logic signed [32:0] mul_a, mul_b;
  logic signed [47:0] mul_fa, mul_fb;
  logic mul_hi;
  logic signed [32:0] dd;
  logic div_go_d;
  logic dv_done;
  logic signed [47:0] dv_q;
  logic [1:0] lsel;
  logic signed [31:0] qc;
  logic [XA-1:0] ra_x;
  logic [YA-1:0] ra_y;

  // clamp counts to [3, max]
  always_comb begin
    if (x_count < 7'd3) nx1 = XA'(2);
    else if (32'(x_count) > MAX_X_POINTS) nx1 = XA'(MAX_X_POINTS - 1);
    else nx1 = XA'(x_count - 7'd1);
    if (y_count < 8'd3) ny1 = YA'(2);
    else if (32'(y_count) > MAX_Y_POINTS) ny1 = YA'(MAX_Y_POINTS - 1);
    else ny1 = YA'(y_count - 8'd1);
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      q <= item;
      if (item.operation == OP_LOAD_X && 32'(item.row_index) < MAX_X_POINTS)
        xmem[XA'(item.row_index)] <= item.grid_value;
      if (item.operation == OP_LOAD_Y && 32'(item.col_index) < MAX_Y_POINTS)
        ymem[YA'(item.col_index)] <= item.grid_value;
      if (item.operation == OP_LOAD_V && 32'(item.row_index) < MAX_X_POINTS
          && 32'(item.col_index) < MAX_Y_POINTS)
        vmem[{XA'(item.row_index), YA'(item.col_index)}] <= item.entry_value;
    end
  end

  // probe / scan address
  always_comb begin
    logic [CA-1:0] last;
    last = cmd.probe_y ? CA'(ny1) : CA'(nx1);
    unique case (cmd.probe_sel)
      2'd0:    raddr = CA'(1);
      2'd1:    raddr = last - CA'(1);
      2'd2:    raddr = CA'(0);
      default: raddr = last;
    endcase
    if (cmd.scan) raddr = iidx;
    ra_x = XA'(raddr);
    ra_y = YA'(raddr);
  end

  always_ff @(posedge clk) begin
    if (cmd.probe || cmd.scan) rd <= cmd.probe_y ? ymem[ra_y] : xmem[ra_x];
  end

  always_ff @(posedge clk) begin
    logic [YA-1:0] cj;
    logic [XA-1:0] ci;
    ci = cmd.fetch_sel[1] ? il : ih;
    cj = cmd.fetch_sel[0] ? jh : jl;
    if (cmd.fetch) vrd <= vmem[{ci, cj}];
  end

  assign qc = cmd.probe_y ? q.query_y : q.query_x;

  // probe read data passes through rd, then lands in g1/gn2/gs/ge as steered by probe_d/psel_d
  logic [1:0] psel_d;
  logic probe_d;
  always_ff @(posedge clk) begin
    probe_d <= cmd.probe;
    psel_d  <= cmd.probe_sel;
    if (probe_d) begin
      unique case (psel_d)
        2'd0:    g1 <= rd;
        2'd1:    gn2 <= rd;
        2'd2:    gs <= rd;
        default: ge <= rd;
      endcase
    end
  end

  // asc resolves from g1/gn2; start/end values follow
  logic signed [31:0] gmin, gmax;
  logic [CA-1:0] lastc;
  always_comb begin
    lastc = cmd.probe_y ? CA'(ny1) : CA'(nx1);
    asc   = g1 < gn2;
    gmin  = asc ? gs : ge;
    gmax  = asc ? ge : gs;
    start = asc ? CA'(0) : lastc;
    endi  = asc ? lastc : CA'(0);
  end
  assign sts.range_ok = !(qc < gmin || qc > gmax);
  assign sts.scan_stop = !(qc > rd) || (iidx == endi);

  logic [CA-1:0] lo_i;
  always_comb begin
    if (iidx == start) lo_i = asc ? iidx + CA'(1) : iidx - CA'(1);
    else lo_i = asc ? iidx - CA'(1) : iidx + CA'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) iidx <= start;
    else if (cmd.scan_step) iidx <= asc ? iidx + CA'(1) : iidx - CA'(1);
    if (cmd.cell_latch) begin
      if (cmd.probe_y) begin
        jh <= YA'(iidx); jl <= YA'(lo_i);
      end else begin
        ih <= XA'(iidx); il <= XA'(lo_i);
      end
    end
  end

  // read the cell end coordinates through one port: hi ends first, lo ends next
  assign ce_x = cmd.fetch_sel[0] ? il : ih;
  assign ce_y = cmd.fetch_sel[0] ? jl : jh;

  logic [1:0] fsel_d;
  logic fetch_d;
  always_ff @(posedge clk) begin
    fetch_d <= cmd.fetch;
    fsel_d  <= cmd.fetch_sel;
    if (fetch_d) begin
      unique case (fsel_d)
        2'd0:    fb0 <= vrd; // ih,jl
        2'd1:    fb1 <= vrd; // ih,jh
        2'd2:    fa0 <= vrd; // il,jl
        default: fa1 <= vrd;
      endcase
    end
    if (cmd.fetch && cmd.fetch_sel == 2'd0) begin
      xh <= xmem[ce_x]; yh <= ymem[ce_y];
    end else if (cmd.fetch && cmd.fetch_sel == 2'd1) begin
      xl <= xmem[ce_x]; yl <= ymem[ce_y];
    end
  end
  assign sts.dy_zero = (yh == yl);
  assign sts.dx_zero = (xh == xl);

  // multiply stage: u*fa and t*fb, registered
  always_comb begin
    if (cmd.lerp_sel == 2'd2) begin
      mul_a = 33'(xh) - 33'(q.query_x);
      mul_b = 33'(q.query_x) - 33'(xl);
      mul_fa = ga; mul_fb = gb;
    end else begin
      mul_a = 33'(yh) - 33'(q.query_y);
      mul_b = 33'(q.query_y) - 33'(yl);
      mul_fa = cmd.lerp_sel[0] ? fa0 : fb0;
      mul_fb = cmd.lerp_sel[0] ? fa1 : fb1;
    end
  end

  // low 32 bits of each value on the first cycle, upper 16 bits added on the next
  always_ff @(posedge clk) begin
    mul_hi <= cmd.mul_go;
    if (cmd.mul_go) begin
      prod_a <= 97'(mul_a * $signed({1'b0, mul_fa[31:0]}));
      prod_b <= 97'(mul_b * $signed({1'b0, mul_fb[31:0]}));
      dd     <= (cmd.lerp_sel == 2'd2) ? 33'(xh) - 33'(xl) : 33'(yh) - 33'(yl);
      lsel   <= cmd.lerp_sel;
    end else if (mul_hi) begin
      prod_a <= prod_a + (97'(mul_a * $signed(mul_fa[47:32])) <<< 32);
      prod_b <= prod_b + (97'(mul_b * $signed(mul_fb[47:32])) <<< 32);
    end
    div_go_d <= cmd.div_go;
    if (dv_done) begin
      if (lsel == 2'd0) gb <= dv_q;
      else if (lsel == 2'd1) ga <= dv_q;
    end
  end

  bti_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go_d),
    .num  (prod_a + prod_b),
    .den  (dd),
    .done (dv_done),
    .quo  (dv_q)
  );
  assign sts.div_done = dv_done;

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.out_of_range <= 1'b1;
      result.interp_value <= '0;
    end else if (dv_done && lsel == 2'd2) begin
      result.out_of_range <= 1'b0;
      result.interp_value <= dv_q;
    end else if (dv_done && lsel == 2'd0 && sts.dx_zero) begin
      result.out_of_range <= 1'b0;
      result.interp_value <= dv_q;
    end
  end
endmodule

/* sv/bti_control.sv */
// ----------------------------------------------------------------------------
// bti_control: query sequencer
// Steps grid probes, linear cell scans, table fetches and up to three divisions.
// ----------------------------------------------------------------------------
module bti_control (
  input  logic          clk,
  input  logic          rst,
  input  logic          query,
  input  bti_pkg::sts_t sts,
  output bti_pkg::cmd_t cmd,
  output logic          active,
  output logic          strobe
);
  import bti_pkg::*;

  state_t state, state_next;
  logic [1:0] cnt, cnt_next;
  logic y, y_next;
  logic [1:0] phase, phase_next;
  logic strobe_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; cnt <= '0; y <= 1'b0; phase <= '0; strobe <= 1'b0;
    end else begin
      state <= state_next; cnt <= cnt_next; y <= y_next; phase <= phase_next;
      strobe <= strobe_next;
    end
  end

  assign active = (state != ST_IDLE);

  always_comb begin
    state_next = state; cnt_next = cnt; y_next = y; phase_next = phase;
    strobe_next = 1'b0;
    cmd = '0;
    cmd.probe_y = y;
    unique case (state)
      ST_IDLE: begin
        if (query) begin
          state_next = ST_XPROBE; cnt_next = '0; y_next = 1'b0;
        end
      end
      ST_XPROBE, ST_YPROBE: begin
        cmd.probe = 1'b1; cmd.probe_sel = cnt; cnt_next = cnt + 2'd1;
        if (cnt == 2'd3) state_next = y ? ST_YWAIT : ST_XWAIT;
      end
      ST_XWAIT, ST_YWAIT: begin
        // wait for the probe pipeline to drain
        cnt_next = cnt + 2'd1;
        if (cnt == 2'd1) begin
          cnt_next = '0;
          if (!sts.range_ok) begin
            cmd.finish = 1'b1; strobe_next = 1'b1; state_next = ST_IDLE;
          end else begin
            cmd.scan_init = 1'b1; state_next = y ? ST_YSCAN : ST_XSCAN;
          end
        end
      end
      ST_XSCAN, ST_YSCAN: begin
        cmd.scan = 1'b1; state_next = y ? ST_YSCAN_W : ST_XSCAN_W;
      end
      ST_XSCAN_W, ST_YSCAN_W: begin
        if (sts.scan_stop) begin
          cmd.cell_latch = 1'b1;
          if (y) state_next = ST_FETCH;
          else begin
            y_next = 1'b1; cnt_next = '0; state_next = ST_YPROBE;
          end
        end else begin
          cmd.scan_step = 1'b1; state_next = y ? ST_YSCAN : ST_XSCAN;
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1; cmd.fetch_sel = cnt; cnt_next = cnt + 2'd1;
        if (cnt == 2'd3) begin
          cnt_next = '0; state_next = ST_FETCH_W;
        end
      end
      ST_FETCH_W: begin
        cnt_next = cnt + 2'd1;
        if (cnt == 2'd1) begin
          cnt_next = '0; phase_next = 2'd0;
          if (sts.dy_zero) begin
            cmd.finish = 1'b1; strobe_next = 1'b1; state_next = ST_IDLE;
          end else state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_go = 1'b1; cmd.lerp_sel = phase; state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_go = 1'b1; cmd.lerp_sel = phase; state_next = ST_DIV_W;
      end
      ST_DIV_W: begin
        cmd.lerp_sel = phase;
        if (sts.div_done) begin
          if (phase == 2'd2 || (phase == 2'd0 && sts.dx_zero)) state_next = ST_DONE;
          else begin
            phase_next = phase + 2'd1; state_next = ST_MUL;
          end
        end
      end
      ST_DONE: begin
        strobe_next = 1'b1; state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

/* sv/bilinear_table_interpolator.sv */
// ----------------------------------------------------------------------------
// bilinear_table_interpolator: 2-D table with bilinear query
//
//  channel  | handshake            | payload
//  in       | start / busy         | in_item  (bti_pkg::in_item_t)
//  out      | done (1-cycle pulse) | out_item (bti_pkg::out_item_t)
//  cfg      | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// Loads do not raise busy. A query holds busy through the grid probes, the
// linear grid scans, the table fetches and up to three bit-serial divisions
// (one when the x cell has zero width). Out-of-range queries end after the
// probes, and queries whose y cell has zero width end after the fetches.
// Reset is synchronous and clears control and the grid counts only; memories
// hold garbage until loaded. cfg_ready is low while busy. Results cannot be stalled.
// ----------------------------------------------------------------------------
module bilinear_table_interpolator #(
  parameter int MAX_X_POINTS = 64,
  parameter int MAX_Y_POINTS = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  bti_pkg::in_item_t  in_item,
  output logic               done,
  output bti_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);
  import bti_pkg::*;

  logic [6:0] x_count;
  logic [7:0] y_count;
  logic accept, active;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = !busy;
  assign accept = start && !busy;
  assign busy = active || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_count <= 7'd64; y_count <= 8'd128;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_X_COUNT) x_count <= cfg_data[6:0];
      else y_count <= cfg_data[7:0];
    end
  end

  bti_control u_ctl (
    .clk(clk), .rst(rst),
    .query(accept && in_item.operation == OP_QUERY),
    .sts(sts), .cmd(cmd), .active(active), .strobe(done)
  );

  bti_datapath #(.MAX_X_POINTS(MAX_X_POINTS), .MAX_Y_POINTS(MAX_Y_POINTS)) u_dp (
    .clk(clk), .rst(rst), .load_en(accept), .item(in_item),
    .x_count(x_count), .y_count(y_count), .cmd(cmd), .sts(sts), .result(out_item)
  );
endmodule

/* sv/bti_checker.sv */
// ----------------------------------------------------------------------------
// bti_checker: port-level checks for the interpolator
// Watches handshake and result ports over time.
// ----------------------------------------------------------------------------
module bti_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input bti_pkg::in_item_t  in_item,
  input bti_pkg::out_item_t out_item
);
  import bti_pkg::*;

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && in_item.operation == OP_QUERY |=> busy)
    else $error("query did not raise busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done longer than one cycle");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && out_item.out_of_range |-> out_item.interp_value == '0)
    else $error("error result not zero");
endmodule

bind bilinear_table_interpolator bti_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .in_item(in_item), .out_item(out_item)
);

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// Bilinear table interpolator testbench
// Loads random x/y grids (ascending, descending, unordered, with repeated
// points) and value tables under several grid-size settings, then queries
// the table inside, on and outside the grids. A built-in predictor computes
// each expected result, which is checked against the block's output.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import bti_pkg::*;

  localparam int NX = 64;
  localparam int NY = 128;
  localparam longint CycleLimit = 5_000_000;
  localparam int SettleCycles = 800;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      done;
  out_item_t out_item;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_index;
  logic [31:0] cfg_data;

  bilinear_table_interpolator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .done(done), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state
  logic signed [31:0] x_pts [NX];
  logic signed [31:0] y_pts [NY];
  logic signed [47:0] values [NX*NY];
  logic [6:0] x_count_reg;
  logic [7:0] y_count_reg;

  in_item_t  pending_items [$];
  out_item_t expected_results [$];
  int fail_count;
  longint cycle_count;
  int gap_left;
  int burst_left;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  task automatic report(input string what);
    $display("ERROR at cycle %0d: %s", cycle_count, what);
    fail_count++;
  endtask

  function automatic int clamp_count(input int c, input int maxv);
    if (c < 3) return 3;
    if (c > maxv) return maxv;
    return c;
  endfunction

  function automatic logic signed [31:0] grid_pt(input bit is_y, input int i);
    return is_y ? y_pts[i] : x_pts[i];
  endfunction

  // hi is the first point not below q; lo closes the cell
  function automatic bit locate_cell(input bit is_y, input int n,
                                     input logic signed [31:0] q,
                                     output int hi, output int lo);
    bit asc;
    int first, last, i;
    asc = grid_pt(is_y, 1) < grid_pt(is_y, n - 2);
    first = asc ? 0 : n - 1;
    last = asc ? n - 1 : 0;
    hi = 0;
    lo = 0;
    if (q < grid_pt(is_y, first) || q > grid_pt(is_y, last)) return 1'b0;
    i = first;
    while (q > grid_pt(is_y, i) && i != last) i = asc ? i + 1 : i - 1;
    hi = i;
    if (i == first) lo = asc ? i + 1 : i - 1;
    else lo = asc ? i - 1 : i + 1;
    return 1'b1;
  endfunction

  // (u*fa + t*fb)/d, round half away from zero, saturate to 48 bits
  function automatic logic signed [47:0] blend(input longint u, input longint t,
                                               input longint fa, input longint fb,
                                               input longint d);
    logic signed [127:0] su, st, sa, sb, num;
    logic [127:0] mag_n, mag_d, quo, rem, lim;
    bit neg;
    su = u; st = t; sa = fa; sb = fb;
    num = su * sa + st * sb;
    neg = num[127] != (d < 0);
    mag_n = num[127] ? -num : num;
    mag_d = (d < 0) ? -d : d;
    quo = mag_n / mag_d;
    rem = mag_n % mag_d;
    if (rem >= mag_d - rem) quo++;
    lim = neg ? (128'd1 << 47) : (128'd1 << 47) - 1;
    if (quo > lim) quo = lim;
    return neg ? 48'(-quo) : 48'(quo);
  endfunction

  function automatic void predict_item(input in_item_t it);
    int nx, ny, ih, il, jh, jl;
    longint qx, qy, dy, uy, ty, ga, gb, s;
    out_item_t res;
    case (op_t'(it.operation))
      OP_LOAD_X: x_pts[it.row_index] = it.grid_value;
      OP_LOAD_Y: y_pts[it.col_index] = it.grid_value;
      OP_LOAD_V: values[it.row_index * NY + it.col_index] = it.entry_value;
      default: begin
        res.interp_value = '0;
        res.out_of_range = 1'b1;
        qx = it.query_x;
        qy = it.query_y;
        nx = clamp_count(x_count_reg, NX);
        ny = clamp_count(y_count_reg, NY);
        if (locate_cell(1'b0, nx, it.query_x, ih, il) &&
            locate_cell(1'b1, ny, it.query_y, jh, jl)) begin
          dy = longint'(y_pts[jh]) - longint'(y_pts[jl]);
          if (dy != 0) begin
            uy = longint'(y_pts[jh]) - qy;
            ty = qy - longint'(y_pts[jl]);
            gb = blend(uy, ty, values[ih*NY + jl], values[ih*NY + jh], dy);
            if (x_pts[ih] == x_pts[il]) begin
              s = gb;
            end else begin
              ga = blend(uy, ty, values[il*NY + jl], values[il*NY + jh], dy);
              s = blend(longint'(x_pts[ih]) - qx, qx - longint'(x_pts[il]), ga, gb,
                        longint'(x_pts[ih]) - longint'(x_pts[il]));
            end
            res.interp_value = s[47:0];
            res.out_of_range = 1'b0;
          end
        end
        expected_results.push_back(res);
      end
    endcase
  endfunction

  // Driver: hand items from the pending queue to the block
  always @(posedge clk) begin
    logic next_start;
    if (!rst) begin
      next_start = start;
      if (start && !busy) begin
        predict_item(in_item);
        next_start = 1'b0;
      end
      if (!next_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() != 0) begin
          in_item <= pending_items.pop_front();
          next_start = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
            gap_left = 0;
          end else begin
            if ($urandom_range(0, 39) == 0) burst_left = 30;
            gap_left = $urandom_range(0, 14);
          end
        end
      end
      start <= next_start;
    end
  end

  // Monitor: check each result against the oldest expectation
  always @(posedge clk) begin
    out_item_t exp_res;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result value=%0d oor=%0b",
                         out_item.interp_value, out_item.out_of_range));
      end else begin
        exp_res = expected_results.pop_front();
        if (out_item.interp_value !== exp_res.interp_value)
          report($sformatf("interp_value %0d, expected %0d",
                           out_item.interp_value, exp_res.interp_value));
        if (out_item.out_of_range !== exp_res.out_of_range)
          report($sformatf("out_of_range %0b, expected %0b",
                           out_item.out_of_range, exp_res.out_of_range));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || start || expected_results.size() != 0);
  endtask

  task automatic write_reg(input logic idx, input int count);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= {$urandom()} & 32'hFFFF_FF00 | 32'(count);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_X_COUNT) x_count_reg = 7'(count);
    else y_count_reg = 8'(count);
  endtask

  task automatic push_load(input op_t op, input int row, input int col,
                           input logic signed [31:0] gv, input logic signed [47:0] ev);
    in_item_t it;
    it = '0;
    it.operation = op;
    it.row_index = 6'(row);
    it.col_index = 7'(col);
    it.grid_value = gv;
    it.entry_value = ev;
    it.query_x = $urandom();
    it.query_y = $urandom();
    pending_items.push_back(it);
  endtask

  task automatic push_query(input logic signed [31:0] qx, input logic signed [31:0] qy);
    in_item_t it;
    it.operation = OP_QUERY;
    it.row_index = $urandom();
    it.col_index = $urandom();
    it.grid_value = $urandom();
    it.entry_value = {$urandom(), $urandom()};
    it.query_x = qx;
    it.query_y = qy;
    pending_items.push_back(it);
  endtask

  function automatic logic signed [47:0] rand_entry();
    case ($urandom_range(0, 7))
      0: return 48'sh7FFF_FFFF_FFFF;
      1: return 48'sh8000_0000_0000;
      2: return '0;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic void make_grid(ref int g[$], input int n);
    int kind, cur, smax;
    g.delete();
    kind = $urandom_range(0, 5);
    cur = $signed($urandom()) >>> 3;
    smax = 1 << $urandom_range(0, 22);
    for (int i = 0; i < n; i++) begin
      g.push_back(cur);
      if (kind == 5) cur = $signed($urandom()) >>> 3;
      else if ($urandom_range(0, 7) != 0) begin
        if (kind < 3) cur += $urandom_range(0, smax);
        else cur -= $urandom_range(0, smax);
      end
    end
  endfunction

  function automatic int pick_coord(ref int g[$]);
    int lo, hi;
    lo = g[0];
    hi = g[0];
    foreach (g[i]) begin
      if (g[i] < lo) lo = g[i];
      if (g[i] > hi) hi = g[i];
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return int'(longint'(lo) + $urandom_range(0, 32'(hi - lo)));
      6, 7: return g[$urandom_range(0, g.size() - 1)];
      8: return $urandom_range(0, 1) ? lo - 1 : hi + 1;
      default: return $urandom();
    endcase
  endfunction

  // One setting of the grid sizes: load grids and table, then query
  task automatic run_phase(input int cx, input int cy, input int n_query);
    int nx, ny, r, c;
    int gx[$], gy[$];
    wait_idle();
    repeat (SettleCycles) @(posedge clk);
    write_reg(CFG_X_COUNT, cx);
    write_reg(CFG_Y_COUNT, cy);
    nx = clamp_count(cx, NX);
    ny = clamp_count(cy, NY);
    make_grid(gx, nx);
    make_grid(gy, ny);
    foreach (gx[i]) push_load(OP_LOAD_X, i, $urandom_range(0, 127), gx[i], rand_entry());
    foreach (gy[i]) push_load(OP_LOAD_Y, $urandom_range(0, 63), i, gy[i], rand_entry());
    for (int i = 0; i < nx; i++)
      for (int j = 0; j < ny; j++)
        push_load(OP_LOAD_V, i, j, $urandom(), rand_entry());
    for (int k = 0; k < n_query; k++) begin
      case ($urandom_range(0, 9))
        0: begin
          r = $urandom_range(0, nx - 1);
          c = $urandom_range(0, ny - 1);
          push_load(OP_LOAD_V, r, c, $urandom(), rand_entry());
        end
        1: begin
          // move one grid point; repeats and disorder are fine
          r = $urandom_range(0, nx - 1);
          gx[r] = pick_coord(gx);
          push_load(OP_LOAD_X, r, $urandom_range(0, 127), gx[r], rand_entry());
        end
        default: ;
      endcase
      push_query(pick_coord(gx), pick_coord(gy));
    end
  endtask

  initial begin
    logic signed [31:0] ext [3];
    rst = 1'b1;
    start = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_X_COUNT;
    cfg_data = '0;
    x_count_reg = 7'd64;
    y_count_reg = 8'd128;
    fail_count = 0;
    cycle_count = 0;
    gap_left = 0;
    burst_left = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: full-scale grids and extreme table values at three points
    write_reg(CFG_X_COUNT, 3);
    write_reg(CFG_Y_COUNT, 3);
    ext = '{32'sh7FFF_FFFF, 32'sh0, 32'sh8000_0000};
    for (int i = 0; i < 3; i++) begin
      push_load(OP_LOAD_X, i, 0, ext[i], '0);
      push_load(OP_LOAD_Y, 0, i, ext[i], '0);
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        push_load(OP_LOAD_V, i, j, '0,
                  ((i + j) % 2) ? 48'sh7FFF_FFFF_FFFF : 48'sh8000_0000_0000);
    push_query(32'sh8000_0000, 32'sh8000_0000);
    push_query(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    push_query(32'sh0, 32'sh0);
    push_query(32'sh1, 32'shFFFF_FFFF);
    push_query(32'sh4000_0000, 32'shC000_0000);
    push_query(32'sh8000_0000, 32'sh7FFF_FFFF);

    // Register extremes, including values that clamp
    run_phase(0, 1, 40);
    run_phase(127, 2, 60);
    run_phase(1, 255, 60);
    for (int p = 0; p < 5; p++)
      run_phase($urandom_range(0, 9) == 0 ? $urandom_range(11, 20) : $urandom_range(3, 8),
                $urandom_range(0, 9) == 0 ? $urandom_range(11, 30) : $urandom_range(3, 8),
                60);

    wait_idle();
    repeat (SettleCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
